/* design/ssi_pkg.sv */
// ----------------------------------------------------------------------------
// ssi_pkg: shared types and constants
// Item layouts, pipeline payload structs and alpha lane helpers.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int InDataW  = 320;
  localparam int OutDataW = 64;
  localparam int RadLsb   = 96;
  localparam int StartLsb = 127;
  localparam int EndLsb   = 223;
  localparam int SqrtCells = 61;
  localparam logic [32:0] ScaleLim = 33'd536870912;

  typedef struct packed {
    logic               zero;
    logic               t0;
    logic               t1;
    logic               dneg;
    logic [59:0]        a;
    logic signed [60:0] b;
  } ssi_ctl_t;

  typedef struct packed {
    ssi_ctl_t     ctl;
    logic [63:0]  rem;
    logic [60:0]  root;
    logic [121:0] rad;
  } ssi_sqrt_t;

  typedef struct packed {
    logic        fixed;
    logic [60:0] rem;
    logic [30:0] q;
  } ssi_lane_t;

  typedef struct packed {
    logic        hit;
    logic [59:0] a;
    ssi_lane_t   ent;
    ssi_lane_t   ext;
  } ssi_div_t;

  function automatic ssi_lane_t lane_fix(logic [30:0] val);
    ssi_lane_t l;
    l.fixed = 1'b1;
    l.rem   = '0;
    l.q     = val;
    return l;
  endfunction

  function automatic ssi_lane_t lane_of(logic signed [63:0] num, logic [59:0] a,
                                        logic [30:0] one);
    ssi_lane_t l;
    l = lane_fix('0);
    if (num <= 64'sd0) begin
      l = lane_fix('0);
    end else if (num >= $signed({4'b0, a})) begin
      l = lane_fix(one);
    end else begin
      l.fixed = 1'b0;
      l.rem   = num[60:0];
      l.q     = '0;
    end
    return l;
  endfunction

endpackage

/* design/sphere_segment_intersect_core.sv */
// ----------------------------------------------------------------------------
// sphere_segment_intersect_core: clipped segment against sphere test
// Each input item carries one sphere and one segment; each gives one result
// item with a hit flag and the entry and exit alphas (Q.ALPHA_FRAC_BITS).
//
// Input channel s_axis: tdata carries center x/y/z, radius, start x/y/z and
// end x/y/z; tuser carries the zero-length flag. Output channel m_axis:
// tdata carries entry and exit alpha, tuser the hit flag.
// The pipeline is seven set-up stages, a row of 61 square-root cells (one
// root bit each), one case-select stage, a row of ALPHA_FRAC_BITS divider
// cells (one quotient bit each) and the output register. One item enters
// per cycle while the skid register is empty; the row of cells sets that rate.
// Reset empties every stage; no item is in flight afterwards. When the
// receiver stalls, the result waiting in the output register holds and one
// more result goes to a skid register; the pipeline freezes only once the
// skid register is full and resumes the cycle after it drains.
// ----------------------------------------------------------------------------
module sphere_segment_intersect_core #(
  parameter int ALPHA_FRAC_BITS = 30
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // center_x, center_y, center_z, sphere_radius, start_x, start_y, start_z,
  // end_x, end_y, end_z, zero pad
  input  logic [319:0]  s_axis_tdata,
  // zero_length
  input  logic [0:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // entry_alpha, exit_alpha, zero pad
  output logic [63:0]   m_axis_tdata,
  // hit
  output logic [0:0]    m_axis_tuser
);
  import ssi_pkg::*;

  localparam logic [30:0] AlphaOne = 31'(1) << ALPHA_FRAC_BITS;

  logic en;
  logic skid_v_q, out_v_q;
  logic [63:0] out_data_q, skid_data_q;
  logic        out_hit_q, skid_hit_q;

  logic      sq_vld [SqrtCells + 1];
  ssi_sqrt_t sq_chain [SqrtCells + 1];
  logic      dv_vld [ALPHA_FRAC_BITS + 1];
  ssi_div_t  dv_chain [ALPHA_FRAC_BITS + 1];

  ssi_sqrt_t          sc;
  logic signed [63:0] nb, n0, n1;
  ssi_div_t           sel;
  logic               sel_v_q;
  ssi_div_t           sel_q;

  logic        arrive;
  logic [63:0] arrive_data;
  logic        arrive_hit;

  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  ssi_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .data_i  (s_axis_tdata),
    .zero_i  (s_axis_tuser[0]),
    .valid_o (sq_vld[0]),
    .data_o  (sq_chain[0])
  );

  for (genvar k = 0; k < SqrtCells; k++) begin : g_sqrt
    ssi_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_vld[k]),
      .data_i  (sq_chain[k]),
      .valid_o (sq_vld[k+1]),
      .data_o  (sq_chain[k+1])
    );
  end

  assign sc = sq_chain[SqrtCells];
  assign nb = -64'(sc.ctl.b);
  assign n0 = nb - $signed({3'b0, sc.root});
  assign n1 = nb + $signed({3'b0, sc.root});

  always_comb begin
    sel.hit = 1'b1;
    sel.a   = sc.ctl.a;
    sel.ent = lane_fix('0);
    sel.ext = lane_fix('0);
    if (sc.ctl.zero) begin
      sel.hit = sc.ctl.t0;
    end else if (sc.ctl.t0 && sc.ctl.t1) begin
      sel.ext = lane_fix(AlphaOne);
    end else if (sc.ctl.t0) begin
      if (sc.ctl.a != '0) begin
        sel.ext = lane_of((n0 >= 64'sd0) ? n0 : n1, sc.ctl.a, AlphaOne);
      end
    end else if (sc.ctl.t1) begin
      sel.ext = lane_fix(AlphaOne);
      sel.ent = (sc.ctl.a == '0) ? lane_fix(AlphaOne) : lane_of(n0, sc.ctl.a, AlphaOne);
    end else if (sc.ctl.a == '0 || sc.ctl.dneg || n0 > $signed({4'b0, sc.ctl.a}) ||
                 n1 < 64'sd0) begin
      sel.hit = 1'b0;
    end else begin
      sel.ent = lane_of(n0, sc.ctl.a, AlphaOne);
      sel.ext = lane_of(n1, sc.ctl.a, AlphaOne);
    end
    if (!sel.hit) begin
      sel.ent = lane_fix('0);
      sel.ext = lane_fix('0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_v_q <= 1'b0;
    end else if (en) begin
      sel_v_q <= sq_vld[SqrtCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sel_q <= sel;
    end
  end

  assign dv_vld[0]   = sel_v_q;
  assign dv_chain[0] = sel_q;

  for (genvar k = 0; k < ALPHA_FRAC_BITS; k++) begin : g_div
    ssi_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_vld[k]),
      .data_i  (dv_chain[k]),
      .valid_o (dv_vld[k+1]),
      .data_o  (dv_chain[k+1])
    );
  end

  assign arrive      = en && dv_vld[ALPHA_FRAC_BITS];
  assign arrive_data = {2'b00, dv_chain[ALPHA_FRAC_BITS].ext.q,
                        dv_chain[ALPHA_FRAC_BITS].ent.q};
  assign arrive_hit  = dv_chain[ALPHA_FRAC_BITS].hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_v_q && !m_axis_tready) begin
      if (arrive) skid_v_q <= 1'b1;
    end else if (skid_v_q) begin
      out_v_q  <= 1'b1;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q <= arrive;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_q && !m_axis_tready) begin
      if (arrive) begin
        skid_data_q <= arrive_data;
        skid_hit_q  <= arrive_hit;
      end
    end else if (skid_v_q) begin
      out_data_q <= skid_data_q;
      out_hit_q  <= skid_hit_q;
    end else begin
      out_data_q <= arrive_data;
      out_hit_q  <= arrive_hit;
    end
  end

  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_hit_q;

`ifndef SYNTHESIS
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready))
    else $error("skid filled while output free");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("miss with nonzero alpha");
  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[30:0] <= AlphaOne && m_axis_tdata[61:31] <= AlphaOne)
    else $error("alpha above one");
`endif

endmodule

/* design/ssi_front.sv */
// ----------------------------------------------------------------------------
// ssi_front: inside tests and quadratic set-up
// Seven stages from coordinates to the discriminant magnitude.
// ----------------------------------------------------------------------------
module ssi_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [319:0]              data_i,
  input  logic                      zero_i,
  output logic                      valid_o,
  output ssi_pkg::ssi_sqrt_t        data_o
);
  import ssi_pkg::*;

  logic [6:0] vld_q;

  logic signed [32:0] d0_q [3];
  logic signed [32:0] d1_q [3];
  logic signed [32:0] dv_q [3];
  logic [30:0]        r1_q;
  logic               z1_q;

  logic [32:0] m0 [3];
  logic [32:0] m1 [3];
  logic [32:0] mv [3];
  logic [32:0] mmax;
  logic [1:0]  sh;

  logic [65:0] sq0_q [3];
  logic [65:0] sq1_q [3];
  logic [61:0] rr_q;
  logic [29:0] psm_q [3];
  logic [29:0] vsm_q [3];
  logic        pss_q [3];
  logic        vss_q [3];
  logic [29:0] rs_q;
  logic        z2_q;

  logic [59:0] va_q [3];
  logic [59:0] pv_q [3];
  logic        pvn_q [3];
  logic [59:0] pp_q [3];
  logic [59:0] rq_q;
  logic        t0_3_q, t1_3_q, z3_q;

  logic [59:0]        a4_q;
  logic signed [60:0] b4_q;
  logic signed [60:0] c4_q;
  logic               t0_4_q, t1_4_q, z4_q;
  logic signed [60:0] bsum;

  logic [59:0] mb, mc;
  logic [59:0] bhh_q, bhl_q, bll_q, ahh_q, ahl_q, alh_q, all_q;
  logic        cneg5_q;
  ssi_ctl_t    ctl5_q;

  logic [119:0] bb6_q, ac6_q;
  logic         cneg6_q;
  ssi_ctl_t     ctl6_q;

  logic [120:0] dm;
  logic         dneg;
  ssi_ctl_t     ctl7;
  ssi_sqrt_t    out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        d0_q[i] <= 33'($signed(data_i[StartLsb + 32*i +: 32])) -
                   33'($signed(data_i[32*i +: 32]));
        d1_q[i] <= 33'($signed(data_i[EndLsb + 32*i +: 32])) -
                   33'($signed(data_i[32*i +: 32]));
        dv_q[i] <= 33'($signed(data_i[EndLsb + 32*i +: 32])) -
                   33'($signed(data_i[StartLsb + 32*i +: 32]));
      end
      r1_q <= data_i[RadLsb +: 31];
      z1_q <= zero_i;
    end
  end

  always_comb begin
    mmax = {2'b0, r1_q};
    for (int i = 0; i < 3; i++) begin
      m0[i] = d0_q[i][32] ? 33'(-d0_q[i]) : 33'(d0_q[i]);
      m1[i] = d1_q[i][32] ? 33'(-d1_q[i]) : 33'(d1_q[i]);
      mv[i] = dv_q[i][32] ? 33'(-dv_q[i]) : 33'(dv_q[i]);
      if (m0[i] > mmax) mmax = m0[i];
      if (mv[i] > mmax) mmax = mv[i];
    end
    if ((mmax >> 2) > ScaleLim) sh = 2'd3;
    else if ((mmax >> 1) > ScaleLim) sh = 2'd2;
    else if (mmax > ScaleLim) sh = 2'd1;
    else sh = 2'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq0_q[i] <= 66'(m0[i]) * 66'(m0[i]);
        sq1_q[i] <= 66'(m1[i]) * 66'(m1[i]);
        psm_q[i] <= 30'(m0[i] >> sh);
        vsm_q[i] <= 30'(mv[i] >> sh);
        pss_q[i] <= d0_q[i][32];
        vss_q[i] <= dv_q[i][32];
      end
      rr_q <= 62'(r1_q) * 62'(r1_q);
      rs_q <= 30'(r1_q >> sh);
      z2_q <= z1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        va_q[i]  <= 60'(vsm_q[i]) * 60'(vsm_q[i]);
        pv_q[i]  <= 60'(psm_q[i]) * 60'(vsm_q[i]);
        pvn_q[i] <= pss_q[i] ^ vss_q[i];
        pp_q[i]  <= 60'(psm_q[i]) * 60'(psm_q[i]);
      end
      rq_q   <= 60'(rs_q) * 60'(rs_q);
      t0_3_q <= (67'(sq0_q[0]) + 67'(sq0_q[1]) + 67'(sq0_q[2])) <= 67'(rr_q);
      t1_3_q <= (67'(sq1_q[0]) + 67'(sq1_q[1]) + 67'(sq1_q[2])) <= 67'(rr_q);
      z3_q   <= z2_q;
    end
  end

  always_comb begin
    bsum = '0;
    for (int i = 0; i < 3; i++) begin
      bsum = pvn_q[i] ? bsum - $signed({1'b0, pv_q[i]}) : bsum + $signed({1'b0, pv_q[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a4_q   <= va_q[0] + va_q[1] + va_q[2];
      b4_q   <= bsum;
      c4_q   <= $signed(61'(pp_q[0]) + 61'(pp_q[1]) + 61'(pp_q[2])) -
                $signed({1'b0, rq_q});
      t0_4_q <= t0_3_q;
      t1_4_q <= t1_3_q;
      z4_q   <= z3_q;
    end
  end

  assign mb = b4_q[60] ? 60'(-b4_q) : 60'(b4_q);
  assign mc = c4_q[60] ? 60'(-c4_q) : 60'(c4_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bhh_q       <= 60'(mb[59:30]) * 60'(mb[59:30]);
      bhl_q       <= 60'(mb[59:30]) * 60'(mb[29:0]);
      bll_q       <= 60'(mb[29:0]) * 60'(mb[29:0]);
      ahh_q       <= 60'(a4_q[59:30]) * 60'(mc[59:30]);
      ahl_q       <= 60'(a4_q[59:30]) * 60'(mc[29:0]);
      alh_q       <= 60'(a4_q[29:0]) * 60'(mc[59:30]);
      all_q       <= 60'(a4_q[29:0]) * 60'(mc[29:0]);
      cneg5_q     <= c4_q[60];
      ctl5_q.zero <= z4_q;
      ctl5_q.t0   <= t0_4_q;
      ctl5_q.t1   <= t1_4_q;
      ctl5_q.dneg <= 1'b0;
      ctl5_q.a    <= a4_q;
      ctl5_q.b    <= b4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bb6_q   <= (120'(bhh_q) << 60) + (120'(bhl_q) << 31) + 120'(bll_q);
      ac6_q   <= (120'(ahh_q) << 60) + ((120'(ahl_q) + 120'(alh_q)) << 30) +
                 120'(all_q);
      cneg6_q <= cneg5_q;
      ctl6_q  <= ctl5_q;
    end
  end

  always_comb begin
    dneg = 1'b0;
    if (cneg6_q) begin
      dm = 121'(bb6_q) + 121'(ac6_q);
    end else if (bb6_q >= ac6_q) begin
      dm = 121'(bb6_q - ac6_q);
    end else begin
      dm   = '0;
      dneg = 1'b1;
    end
    ctl7      = ctl6_q;
    ctl7.dneg = dneg;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.ctl  <= ctl7;
      out_q.rem  <= '0;
      out_q.root <= '0;
      out_q.rad  <= {1'b0, dm};
    end
  end

  assign valid_o = vld_q[6];
  assign data_o  = out_q;

endmodule

/* design/ssi_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// ssi_sqrt_cell: one root bit of the discriminant square root
// Takes two radicand bits, settles one root bit and hands on.
// ----------------------------------------------------------------------------
module ssi_sqrt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  ssi_pkg::ssi_sqrt_t  data_i,
  output logic                valid_o,
  output ssi_pkg::ssi_sqrt_t  data_o
);
  import ssi_pkg::*;

  logic        vld_q;
  ssi_sqrt_t   data_q;
  logic [63:0] rem4;
  logic [63:0] trial;
  logic        ge;

  assign rem4  = {data_i.rem[61:0], data_i.rad[121:120]};
  assign trial = {1'b0, data_i.root, 2'b01};
  assign ge    = rem4 >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q.ctl  <= data_i.ctl;
      data_q.rem  <= ge ? rem4 - trial : rem4;
      data_q.root <= {data_i.root[59:0], ge};
      data_q.rad  <= {data_i.rad[119:0], 2'b00};
    end
  end

  assign valid_o = vld_q;
  assign data_o  = data_q;

endmodule

/* design/ssi_div_cell.sv */
// ----------------------------------------------------------------------------
// ssi_div_cell: one quotient bit for both alpha lanes
// Restoring division step on the entry and exit numerators.
// ----------------------------------------------------------------------------
module ssi_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  ssi_pkg::ssi_div_t  data_i,
  output logic               valid_o,
  output ssi_pkg::ssi_div_t  data_o
);
  import ssi_pkg::*;

  logic      vld_q;
  ssi_div_t  data_q;
  ssi_lane_t ent_d, ext_d;

  function automatic ssi_lane_t step(ssi_lane_t l, logic [59:0] a);
    ssi_lane_t   r;
    logic [61:0] r2;
    logic        ge;
    r  = l;
    r2 = {l.rem, 1'b0};
    ge = r2 >= {2'b0, a};
    if (!l.fixed) begin
      r.rem = ge ? 61'(r2 - {2'b0, a}) : r2[60:0];
      r.q   = {l.q[29:0], ge};
    end
    return r;
  endfunction

  assign ent_d = step(data_i.ent, data_i.a);
  assign ext_d = step(data_i.ext, data_i.a);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q.hit <= data_i.hit;
      data_q.a   <= data_i.a;
      data_q.ent <= ent_d;
      data_q.ext <= ext_d;
    end
  end

  assign valid_o = vld_q;
  assign data_o  = data_q;

endmodule
